// ===== rtl/core/nfha_pkg.sv =====
// Shared types and codes for the next-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package nfha_pkg;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE     = 3'd1;
  localparam logic [2:0] ST_NO_SPACE     = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOC    = 3'd3;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd4;

  localparam logic [16:0] ARENA_MIN_BYTES = 17'd256;

  localparam logic OP_ALLOC = 1'b0;

  typedef enum logic [3:0] {
    S_CLR,
    S_INIT,
    S_IDLE,
    S_A_EVAL,
    S_A_SP1,
    S_A_SP2,
    S_F_B,
    S_F_P,
    S_F_N,
    S_F_M,
    S_F_KB,
    S_F_KN,
    S_F_FW,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/next_fit_heap_allocator_top.sv =====
// Next-fit heap allocator: top level with the list-walking sequencer.
//
// Channels: cfg (cfg_valid/cfg_ready, cfg_data = arena size in bytes,
// saturated to 256..MAX_ARENA_BYTES), in (op, alloc_size, free_address)
// and out (status, address), all valid/ready.
// One item is worked at a time through a two-port header memory.
// Allocate: from idle, the next-fit walk reads one block per step in
// S_A_EVAL; a split adds S_A_SP1 and, if a next block follows,
// S_A_SP2; S_OUT posts the result. Free: the merge reads and writes
// headers in S_F_B to S_F_FW, skipping unneeded states, then S_OUT.
// After reset and after every cfg write the header memory is swept;
// in_ready stays low meanwhile, cfg_ready is always high.
// A result sits in the output register until taken; the next item is
// accepted meanwhile, and its result waits in the sequencer if the
// receiver still stalls.
`timescale 1ns / 1ps
`default_nettype none
module next_fit_heap_allocator_top #(
  parameter int MAX_ARENA_BYTES = 65536,
  parameter int HEADER_BYTES    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [15:0] alloc_size,
  input  wire logic [15:0] free_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [15:0]      address
);

  localparam int AW = $clog2(MAX_ARENA_BYTES);
  localparam logic [16:0]   HB17  = 17'(HEADER_BYTES);
  localparam logic [AW-1:0] HBA   = AW'(HEADER_BYTES);
  localparam logic [16:0]   MAX17 = 17'(MAX_ARENA_BYTES);

  typedef struct packed {
    logic          live;
    logic          free;
    logic          has_prev;
    logic          has_next;
    logic [AW-1:0] size;
    logic [AW-1:0] prev;
    logic [AW-1:0] next;
  } hdr_t;

  localparam int HW = $bits(hdr_t);

  nfha_pkg::state_t state, state_next;
  logic [16:0]   arena, arena_next;
  logic [AW-1:0] rover, rover_next;
  logic [AW-1:0] cnt, cnt_next;
  logic          out_valid_next;
  logic [2:0]    out_st_next;
  logic [15:0]   out_addr_next;

  logic [AW-1:0] cur, cur_next, start, start_next, off, off_next, s, s_next;
  logic [AW-1:0] surv, surv_next, nx, nx_next;
  logic          hn, hn_next, mp, mp_next, mn, mn_next, offbad, offbad_next;
  logic [15:0]   req, req_next;
  hdr_t          blk, blk_next, pblk, pblk_next, nblk, nblk_next;
  logic [2:0]    res_st, res_st_next;
  logic [15:0]   res_addr, res_addr_next;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  hdr_t          wdata, rd;
  logic [HW-1:0] rdata_raw;

  nfha_hdr_ram #(.ADDR_BITS(AW), .WIDTH(HW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );

  assign rd        = hdr_t'(rdata_raw);
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == nfha_pkg::S_IDLE);

  logic [16:0]   sat;
  logic [16:0]   excess, off17;
  logic [AW-1:0] bsz, r1;
  hdr_t          h;

  always_comb begin
    state_next     = state;
    arena_next     = arena;
    rover_next     = rover;
    cnt_next       = cnt;
    out_valid_next = out_valid;
    out_st_next    = status;
    out_addr_next  = address;
    cur_next       = cur;
    start_next     = start;
    off_next       = off;
    s_next         = s;
    surv_next      = surv;
    nx_next        = nx;
    hn_next        = hn;
    mp_next        = mp;
    mn_next        = mn;
    offbad_next    = offbad;
    req_next       = req;
    blk_next       = blk;
    pblk_next      = pblk;
    nblk_next      = nblk;
    res_st_next    = res_st;
    res_addr_next  = res_addr;
    we             = 1'b0;
    waddr          = cur;
    wdata          = '0;
    raddr          = cur;
    sat            = cfg_data;
    excess         = {1'b0, rd.size} - {1'b0, req};
    off17          = {1'b0, free_address} - HB17;
    bsz            = blk.size;
    r1             = rover;
    h              = '0;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      nfha_pkg::S_CLR: begin
        we       = 1'b1;
        waddr    = cnt;
        cnt_next = cnt + 1'b1;
        if (cnt == '1) begin
          state_next = nfha_pkg::S_INIT;
        end
      end
      nfha_pkg::S_INIT: begin
        we         = 1'b1;
        waddr      = '0;
        wdata.live = 1'b1;
        wdata.free = 1'b1;
        wdata.size = AW'(arena - HB17);
        rover_next = '0;
        state_next = nfha_pkg::S_IDLE;
      end
      nfha_pkg::S_IDLE: begin
        if (op == nfha_pkg::OP_ALLOC) begin
          raddr = rover;
        end else begin
          raddr = AW'(off17);
        end
        if (in_valid) begin
          req_next    = alloc_size;
          cur_next    = rover;
          start_next  = rover;
          off_next    = AW'(off17);
          offbad_next = (free_address < 16'(HEADER_BYTES)) || (off17 >= MAX17);
          mp_next     = 1'b0;
          mn_next     = 1'b0;
          state_next  = (op == nfha_pkg::OP_ALLOC) ? nfha_pkg::S_A_EVAL
                                                   : nfha_pkg::S_F_B;
        end
      end
      nfha_pkg::S_A_EVAL: begin
        res_addr_next = '0;
        if (req == '0 || {1'b0, req} > arena - HB17) begin
          res_st_next = nfha_pkg::ST_BAD_SIZE;
          state_next  = nfha_pkg::S_OUT;
        end else if (rd.free && {1'b0, rd.size} >= {1'b0, req}) begin
          blk_next      = rd;
          res_st_next   = nfha_pkg::ST_OK;
          res_addr_next = 16'({1'b0, cur} + HB17);
          rover_next    = cur;
          we            = 1'b1;
          if (excess > HB17) begin
            s_next         = cur + HBA + AW'(req);
            waddr          = cur + HBA + AW'(req);
            wdata.live     = 1'b1;
            wdata.free     = 1'b1;
            wdata.size     = AW'(excess - HB17);
            wdata.has_prev = 1'b1;
            wdata.prev     = cur;
            wdata.has_next = rd.has_next;
            wdata.next     = rd.next;
            state_next     = nfha_pkg::S_A_SP1;
          end else begin
            waddr      = cur;
            wdata      = rd;
            wdata.free = 1'b0;
            state_next = nfha_pkg::S_OUT;
          end
        end else begin
          h.next = rd.has_next ? rd.next : '0;
          if (h.next == start) begin
            res_st_next = nfha_pkg::ST_NO_SPACE;
            rover_next  = start;
            state_next  = nfha_pkg::S_OUT;
          end else begin
            cur_next = h.next;
            raddr    = h.next;
          end
        end
      end
      nfha_pkg::S_A_SP1: begin
        we             = 1'b1;
        waddr          = cur;
        wdata          = blk;
        wdata.has_next = 1'b1;
        wdata.next     = s;
        wdata.size     = AW'(req);
        wdata.free     = 1'b0;
        raddr          = blk.next;
        state_next     = blk.has_next ? nfha_pkg::S_A_SP2 : nfha_pkg::S_OUT;
      end
      nfha_pkg::S_A_SP2: begin
        we         = 1'b1;
        waddr      = blk.next;
        wdata      = rd;
        wdata.prev = s;
        state_next = nfha_pkg::S_OUT;
      end
      nfha_pkg::S_F_B: begin
        res_addr_next = '0;
        res_st_next   = nfha_pkg::ST_OK;
        blk_next      = rd;
        if (offbad || !rd.live) begin
          res_st_next = nfha_pkg::ST_NOT_ALLOC;
          state_next  = nfha_pkg::S_OUT;
        end else if (rd.free) begin
          res_st_next = nfha_pkg::ST_ALREADY_FREE;
          state_next  = nfha_pkg::S_OUT;
        end else if (rd.has_prev) begin
          raddr      = rd.prev;
          state_next = nfha_pkg::S_F_P;
        end else if (rd.has_next) begin
          raddr      = rd.next;
          state_next = nfha_pkg::S_F_N;
        end else begin
          state_next = nfha_pkg::S_F_M;
        end
      end
      nfha_pkg::S_F_P: begin
        pblk_next = rd;
        mp_next   = rd.free;
        raddr     = blk.next;
        state_next = blk.has_next ? nfha_pkg::S_F_N : nfha_pkg::S_F_M;
      end
      nfha_pkg::S_F_N: begin
        nblk_next  = rd;
        mn_next    = rd.free;
        state_next = nfha_pkg::S_F_M;
      end
      nfha_pkg::S_F_M: begin
        if (mn) begin
          bsz = blk.size + nblk.size + HBA;
        end
        h.live     = 1'b1;
        h.free     = 1'b1;
        h.has_next = mn ? nblk.has_next : blk.has_next;
        h.next     = mn ? nblk.next : blk.next;
        if (mp) begin
          h.has_prev = pblk.has_prev;
          h.prev     = pblk.prev;
          h.size     = pblk.size + bsz + HBA;
          waddr      = blk.prev;
          surv_next  = blk.prev;
        end else begin
          h.has_prev = blk.has_prev;
          h.prev     = blk.prev;
          h.size     = bsz;
          waddr      = off;
          surv_next  = off;
        end
        we      = 1'b1;
        wdata   = h;
        hn_next = h.has_next;
        nx_next = h.next;
        r1      = (mn && rover == blk.next) ? off : rover;
        rover_next = (mp && r1 == off) ? blk.prev : r1;
        state_next = nfha_pkg::S_F_KB;
      end
      nfha_pkg::S_F_KB: begin
        we         = mp;
        waddr      = off;
        state_next = nfha_pkg::S_F_KN;
      end
      nfha_pkg::S_F_KN: begin
        we    = mn;
        waddr = blk.next;
        raddr = nx;
        state_next = ((mp || mn) && hn) ? nfha_pkg::S_F_FW : nfha_pkg::S_OUT;
      end
      nfha_pkg::S_F_FW: begin
        we         = 1'b1;
        waddr      = nx;
        wdata      = rd;
        wdata.prev = surv;
        state_next = nfha_pkg::S_OUT;
      end
      nfha_pkg::S_OUT: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_st_next    = res_st;
          out_addr_next  = res_addr;
          state_next     = nfha_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = nfha_pkg::S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      if (cfg_data < nfha_pkg::ARENA_MIN_BYTES) begin
        sat = nfha_pkg::ARENA_MIN_BYTES;
      end else if (cfg_data > MAX17) begin
        sat = MAX17;
      end
      arena_next = sat;
      cnt_next   = '0;
      state_next = nfha_pkg::S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nfha_pkg::S_CLR;
      arena     <= MAX17;
      rover     <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      arena     <= arena_next;
      rover     <= rover_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    status   <= out_st_next;
    address  <= out_addr_next;
    cur      <= cur_next;
    start    <= start_next;
    off      <= off_next;
    s        <= s_next;
    surv     <= surv_next;
    nx       <= nx_next;
    hn       <= hn_next;
    mp       <= mp_next;
    mn       <= mn_next;
    offbad   <= offbad_next;
    req      <= req_next;
    blk      <= blk_next;
    pblk     <= pblk_next;
    nblk     <= nblk_next;
    res_st   <= res_st_next;
    res_addr <= res_addr_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/nfha_hdr_ram.sv =====
// Header store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module nfha_hdr_ram #(
  parameter int ADDR_BITS = 16,
  parameter int WIDTH     = 52
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
